FILE: design/pprej_pkg.sv
// ----------------------------------------------------------------------------
// pprej_pkg
// Shared codes and types for the pulse pileup rejector: operating modes,
// window phases, register indexes and the control group passed to the core.
// ----------------------------------------------------------------------------
package pprej_pkg;

    // Operating modes; the fourth code of the mode register emits and rejects nothing.
    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_DOUBLE = 2'd2;

    // Window phases used in double-pulse mode.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_TAIL = 2'd2;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_MODE          = 2'd0;
    localparam logic [1:0] REG_INHIBIT_TIME  = 2'd1;
    localparam logic [1:0] REG_DOUBLE_WINDOW = 2'd2;
    localparam logic [1:0] REG_RETRIGGER     = 2'd3;

    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;

    typedef struct packed {
        logic [1:0] mode;
        logic       retrigger;
    } ctrl_t;

endpackage

FILE: design/pprej_cfg.sv
// ----------------------------------------------------------------------------
// pprej_cfg
// Configuration register file behind an APB-style port. pready is always
// high; reads return the stored register values.
// ----------------------------------------------------------------------------
module pprej_cfg
    import pprej_pkg::*;
#(
    parameter int TIMER_WIDTH = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    output ctrl_t                  ctrl,
    output logic [TIMER_WIDTH-1:0] inhibit_time,
    output logic [TIMER_WIDTH-1:0] double_window
);

    logic [1:0]             mode_reg;
    logic                   retrigger_reg;
    logic [TIMER_WIDTH-1:0] inhibit_time_reg;
    logic [TIMER_WIDTH-1:0] double_window_reg;
    logic                   wr_en;
    logic [1:0]             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_PASS;
            retrigger_reg     <= 1'b0;
            inhibit_time_reg  <= '0;
            double_window_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODE:          mode_reg          <= pwdata[1:0];
                REG_INHIBIT_TIME:  inhibit_time_reg  <= pwdata[TIMER_WIDTH-1:0];
                REG_DOUBLE_WINDOW: double_window_reg <= pwdata[TIMER_WIDTH-1:0];
                REG_RETRIGGER:     retrigger_reg     <= pwdata[0];
                default:           mode_reg          <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_MODE:          prdata = APB_DATA_W'(mode_reg);
            REG_INHIBIT_TIME:  prdata = APB_DATA_W'(inhibit_time_reg);
            REG_DOUBLE_WINDOW: prdata = APB_DATA_W'(double_window_reg);
            REG_RETRIGGER:     prdata = APB_DATA_W'(retrigger_reg);
            default:           prdata = '0;
        endcase
    end

    assign ctrl.mode      = mode_reg;
    assign ctrl.retrigger = retrigger_reg;
    assign inhibit_time   = inhibit_time_reg;
    assign double_window  = double_window_reg;

endmodule

FILE: design/pprej_core.sv
// ----------------------------------------------------------------------------
// pprej_core
// Edge detection, inhibit and double-pulse windows and statistics counters.
// State advances once for every step. Sample, valid and inhibit results are
// combinational; flags and counters are registered; the top level captures all.
// ----------------------------------------------------------------------------
module pprej_core
    import pprej_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STAT_WIDTH   = 32,
    parameter int TIMER_WIDTH  = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic                    sample_valid,
    input  logic                    clear_stats,
    input  ctrl_t                   ctrl,
    input  logic [TIMER_WIDTH-1:0]  inhibit_time,
    input  logic [TIMER_WIDTH-1:0]  double_window,
    output logic [SAMPLE_WIDTH-1:0] out_sample,
    output logic                    out_valid,
    output logic                    inhibit_active,
    output logic                    reject_flag,
    output logic                    double_reject_flag,
    output logic [STAT_WIDTH-1:0]   input_count,
    output logic [STAT_WIDTH-1:0]   output_count,
    output logic [STAT_WIDTH-1:0]   reject_count,
    output logic [STAT_WIDTH-1:0]   double_count
);

    logic [TIMER_WIDTH-1:0]  single_cd_reg, single_cd_next;
    logic [TIMER_WIDTH-1:0]  tail_cd_reg, tail_cd_next;
    logic [TIMER_WIDTH-1:0]  double_cd_reg, double_cd_next;
    logic [SAMPLE_WIDTH-1:0] cached_reg, cached_next;
    logic [SAMPLE_WIDTH-1:0] held_reg, held_next;
    logic                    prev_lvl_reg;
    logic [1:0]              phase_reg, phase_next;
    logic                    pend_rej_reg, pend_rej_next;
    logic                    pend_dbl_reg, pend_dbl_next;
    logic [STAT_WIDTH-1:0]   in_cnt_reg, in_cnt_next;
    logic [STAT_WIDTH-1:0]   out_cnt_reg, out_cnt_next;
    logic [STAT_WIDTH-1:0]   rej_cnt_reg, rej_cnt_next;
    logic [STAT_WIDTH-1:0]   dbl_cnt_reg, dbl_cnt_next;
    logic                    edge_det;
    logic                    emit;
    logic                    inh;
    logic                    rej_inc;
    logic                    dbl_inc;
    logic                    tail_nz;
    logic [TIMER_WIDTH-1:0]  tail_dec;

    assign edge_det = sample_valid & ~prev_lvl_reg;
    assign tail_nz  = (tail_cd_reg != '0);
    // Saturating decrement of the tail countdown.
    assign tail_dec = tail_nz ? tail_cd_reg - 1'b1 : tail_cd_reg;

    always_comb
    begin
        single_cd_next = single_cd_reg;
        tail_cd_next   = tail_cd_reg;
        double_cd_next = double_cd_reg;
        cached_next    = cached_reg;
        held_next      = held_reg;
        phase_next     = phase_reg;
        emit           = 1'b0;
        inh            = 1'b0;
        rej_inc        = 1'b0;
        dbl_inc        = 1'b0;

        unique case (ctrl.mode)
            MODE_PASS:
            begin
                held_next  = sample;
                emit       = edge_det;
                phase_next = PH_IDLE;
            end
            MODE_SINGLE:
            begin
                if (single_cd_reg != '0)
                begin
                    inh = 1'b1;
                    if (edge_det)
                    begin
                        rej_inc        = 1'b1;
                        single_cd_next = ctrl.retrigger ? inhibit_time
                                                        : single_cd_reg - 1'b1;
                    end
                    else
                    begin
                        single_cd_next = single_cd_reg - 1'b1;
                    end
                end
                else if (edge_det)
                begin
                    held_next      = sample;
                    emit           = 1'b1;
                    single_cd_next = inhibit_time;
                end
                phase_next = PH_IDLE;
            end
            MODE_DOUBLE:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (edge_det)
                        begin
                            tail_cd_next   = inhibit_time;
                            double_cd_next = double_window;
                            cached_next    = sample;
                            phase_next     = PH_WAIT;
                            inh            = 1'b1;
                        end
                    end
                    PH_WAIT:
                    begin
                        inh = 1'b1;
                        if (edge_det)
                        begin
                            // A second pulse inside the window drops the cached one.
                            if (ctrl.retrigger)
                            begin
                                tail_cd_next = inhibit_time;
                            end
                            else
                            begin
                                tail_cd_next = tail_dec;
                                if (double_cd_reg != '0)
                                begin
                                    double_cd_next = double_cd_reg - 1'b1;
                                end
                            end
                            phase_next = PH_TAIL;
                            dbl_inc    = 1'b1;
                        end
                        else
                        begin
                            if (double_cd_reg != '0)
                            begin
                                double_cd_next = double_cd_reg - 1'b1;
                            end
                            else
                            begin
                                held_next  = cached_reg;
                                emit       = 1'b1;
                                phase_next = PH_TAIL;
                            end
                            tail_cd_next = tail_dec;
                        end
                    end
                    PH_TAIL:
                    begin
                        if (edge_det && ctrl.retrigger)
                        begin
                            inh          = 1'b1;
                            tail_cd_next = inhibit_time;
                        end
                        else if (tail_nz)
                        begin
                            inh          = 1'b1;
                            tail_cd_next = tail_dec;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                        rej_inc = edge_det;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
                // Unused mode: only the edge detector and input counter run.
                phase_next = phase_reg;
            end
        endcase
    end

    assign pend_rej_next = rej_inc;
    assign pend_dbl_next = dbl_inc;

    // Counters are cleared last, after this step's increments.
    assign in_cnt_next  = clear_stats ? '0 : in_cnt_reg  + STAT_WIDTH'(edge_det);
    assign out_cnt_next = clear_stats ? '0 : out_cnt_reg + STAT_WIDTH'(emit);
    assign rej_cnt_next = clear_stats ? '0 : rej_cnt_reg + STAT_WIDTH'(rej_inc);
    assign dbl_cnt_next = clear_stats ? '0 : dbl_cnt_reg + STAT_WIDTH'(dbl_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_cd_reg <= '0;
            tail_cd_reg   <= '0;
            double_cd_reg <= '0;
            cached_reg    <= '0;
            held_reg      <= '0;
            prev_lvl_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            pend_rej_reg  <= 1'b0;
            pend_dbl_reg  <= 1'b0;
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            rej_cnt_reg   <= '0;
            dbl_cnt_reg   <= '0;
        end
        else if (step)
        begin
            single_cd_reg <= single_cd_next;
            tail_cd_reg   <= tail_cd_next;
            double_cd_reg <= double_cd_next;
            cached_reg    <= cached_next;
            held_reg      <= held_next;
            prev_lvl_reg  <= sample_valid;
            phase_reg     <= phase_next;
            pend_rej_reg  <= pend_rej_next;
            pend_dbl_reg  <= pend_dbl_next;
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            rej_cnt_reg   <= rej_cnt_next;
            dbl_cnt_reg   <= dbl_cnt_next;
        end
    end

    assign out_sample         = held_next;
    assign out_valid          = emit;
    assign inhibit_active     = inh;
    assign reject_flag        = pend_rej_reg;
    assign double_reject_flag = pend_dbl_reg;
    assign input_count        = in_cnt_reg;
    assign output_count       = out_cnt_reg;
    assign reject_count       = rej_cnt_reg;
    assign double_count       = dbl_cnt_reg;

endmodule

FILE: design/pulse_pileup_rejector_unit.sv
// ----------------------------------------------------------------------------
// pulse_pileup_rejector_unit
// Pileup rejector for a digitizer event stream with an inhibit window and a
// double-pulse window, plus four wrapping statistics counters.
//
// Channel   Direction  Handshake           Contents
// s_axis    in         s_tvalid/s_tready   one sample clock: sample and flags
// m_axis    out        m_tvalid/m_tready   one result for each input item
// apb       in         psel/penable        mode, timers, retrigger
//
// An accepted item passes through the input register, then through the window
// logic into the output register. One item is accepted every cycle while the
// output side keeps up; a stalled output holds its result and the input
// register, and s_tready drops only when both are full. Reset clears the
// window state, the counters, the configuration registers and both valid
// flags; the data registers are not reset.
// ----------------------------------------------------------------------------
module pulse_pileup_rejector_unit
    import pprej_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STAT_WIDTH   = 32,
    parameter int TIMER_WIDTH  = 24,
    localparam int IN_W        = SAMPLE_WIDTH + 2,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = SAMPLE_WIDTH + 4 + 4 * STAT_WIDTH,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // sample, sample_valid, clear_stats, zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_sample, out_valid, inhibit_active, reject_flag, double_reject_flag,
    // input_count, output_count, reject_count, double_count, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    ctrl_t                   ctrl;
    logic [TIMER_WIDTH-1:0]  inhibit_time;
    logic [TIMER_WIDTH-1:0]  double_window;

    logic                    in_vld_reg;
    logic [SAMPLE_WIDTH-1:0] in_smp_reg;
    logic                    in_lvl_reg;
    logic                    in_clr_reg;
    logic                    out_vld_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg, out_data_next;
    logic                    advance;

    logic [SAMPLE_WIDTH-1:0] res_sample;
    logic                    res_valid;
    logic                    res_inh;
    logic                    res_rej;
    logic                    res_dbl;
    logic [STAT_WIDTH-1:0]   res_in_cnt;
    logic [STAT_WIDTH-1:0]   res_out_cnt;
    logic [STAT_WIDTH-1:0]   res_rej_cnt;
    logic [STAT_WIDTH-1:0]   res_dbl_cnt;

    // The held item moves on when the output register is free or being read.
    assign advance  = in_vld_reg & (~out_vld_reg | m_tready);
    assign s_tready = ~in_vld_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_smp_reg <= s_tdata[SAMPLE_WIDTH-1:0];
            in_lvl_reg <= s_tdata[SAMPLE_WIDTH];
            in_clr_reg <= s_tdata[SAMPLE_WIDTH+1];
        end
    end

    pprej_cfg #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .ctrl          (ctrl),
        .inhibit_time  (inhibit_time),
        .double_window (double_window)
    );

    pprej_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STAT_WIDTH   (STAT_WIDTH),
        .TIMER_WIDTH  (TIMER_WIDTH)
    ) u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (advance),
        .sample             (in_smp_reg),
        .sample_valid       (in_lvl_reg),
        .clear_stats        (in_clr_reg),
        .ctrl               (ctrl),
        .inhibit_time       (inhibit_time),
        .double_window      (double_window),
        .out_sample         (res_sample),
        .out_valid          (res_valid),
        .inhibit_active     (res_inh),
        .reject_flag        (res_rej),
        .double_reject_flag (res_dbl),
        .input_count        (res_in_cnt),
        .output_count       (res_out_cnt),
        .reject_count       (res_rej_cnt),
        .double_count       (res_dbl_cnt)
    );

    always_comb
    begin
        out_data_next = '0;
        out_data_next[OUT_W-1:0] = {res_dbl_cnt, res_rej_cnt, res_out_cnt, res_in_cnt,
                                    res_dbl, res_rej, res_inh, res_valid, res_sample};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: sim/tb_pulse_pileup_rejector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_pileup_rejector_unit
// Streams sample items through the pileup rejector under bursty input and a
// varying output stall pattern. A scoreboard predicts each result from the
// accepted items and the programmed registers and compares every field.
// ----------------------------------------------------------------------------
module tb_pulse_pileup_rejector_unit;
    import pprej_pkg::*;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 152;

    // Packed from the top bit down, so out_sample ends up in the lowest bits.
    typedef struct packed {
        logic [31:0] double_count;
        logic [31:0] reject_count;
        logic [31:0] output_count;
        logic [31:0] input_count;
        logic        double_reject;
        logic        reject;
        logic        inhibit;
        logic        emitted;
        logic [15:0] sample;
    } rej_result_t;

    class pileup_scoreboard;
        logic [1:0]  mode;
        logic [23:0] inhibit_time;
        logic [23:0] double_window;
        logic        retrigger;
        logic [23:0] single_cd;
        logic [23:0] tail_cd;
        logic [23:0] double_cd;
        logic [15:0] cached;
        logic [15:0] held;
        logic        prev_lvl;
        logic        pend_rej;
        logic        pend_dbl;
        logic [1:0]  phase;
        logic [31:0] counts [4];
        rej_result_t due_results [$];
        int          errors;

        function new();
            mode = MODE_PASS;
            inhibit_time = '0;
            double_window = '0;
            retrigger = 1'b0;
            single_cd = '0;
            tail_cd = '0;
            double_cd = '0;
            cached = '0;
            held = '0;
            prev_lvl = 1'b0;
            pend_rej = 1'b0;
            pend_dbl = 1'b0;
            phase = PH_IDLE;
            for (int k = 0; k < 4; k++) counts[k] = '0;
            errors = 0;
        endfunction

        task report(string msg);
            if (errors < 200) $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_MODE:          mode = value[1:0];
                REG_INHIBIT_TIME:  inhibit_time = value[23:0];
                REG_DOUBLE_WINDOW: double_window = value[23:0];
                default:           retrigger = value[0];
            endcase
        endfunction

        function logic [23:0] sat_dec(logic [23:0] v);
            return (v != 0) ? v - 24'd1 : 24'd0;
        endfunction

        function void note_item(logic [IN_TDATA_W-1:0] d);
            logic [15:0] smp;
            logic        lvl;
            logic        clr;
            logic        rise;
            logic        inh;
            logic        emit;
            rej_result_t r;
            smp = d[15:0];
            lvl = d[16];
            clr = d[17];
            rise = lvl && !prev_lvl;
            inh = 1'b0;
            emit = 1'b0;
            r.input_count  = counts[0];
            r.output_count = counts[1];
            r.reject_count = counts[2];
            r.double_count = counts[3];
            r.reject = pend_rej;
            r.double_reject = pend_dbl;
            prev_lvl = lvl;
            if (rise) counts[0]++;
            pend_rej = 1'b0;
            pend_dbl = 1'b0;
            case (mode)
                MODE_PASS:
                begin
                    held = smp;
                    emit = rise;
                    phase = PH_IDLE;
                end
                MODE_SINGLE:
                begin
                    if (single_cd != 0) begin
                        if (rise) begin
                            single_cd = retrigger ? inhibit_time : single_cd - 24'd1;
                            pend_rej = 1'b1;
                            counts[2]++;
                        end
                        else begin
                            single_cd = single_cd - 24'd1;
                        end
                        inh = 1'b1;
                    end
                    else if (rise) begin
                        held = smp;
                        emit = 1'b1;
                        single_cd = inhibit_time;
                    end
                    phase = PH_IDLE;
                end
                MODE_DOUBLE:
                begin
                    case (phase)
                        PH_IDLE:
                        begin
                            if (rise) begin
                                tail_cd = inhibit_time;
                                double_cd = double_window;
                                cached = smp;
                                phase = PH_WAIT;
                                inh = 1'b1;
                            end
                        end
                        PH_WAIT:
                        begin
                            inh = 1'b1;
                            if (rise) begin
                                if (retrigger) begin
                                    tail_cd = inhibit_time;
                                end
                                else begin
                                    double_cd = sat_dec(double_cd);
                                    tail_cd = sat_dec(tail_cd);
                                end
                                phase = PH_TAIL;
                                pend_dbl = 1'b1;
                                counts[3]++;
                            end
                            else begin
                                if (double_cd != 0) begin
                                    double_cd = double_cd - 24'd1;
                                end
                                else begin
                                    held = cached;
                                    emit = 1'b1;
                                    phase = PH_TAIL;
                                end
                                tail_cd = sat_dec(tail_cd);
                            end
                        end
                        PH_TAIL:
                        begin
                            if (rise && retrigger) begin
                                inh = 1'b1;
                                tail_cd = inhibit_time;
                            end
                            else if (tail_cd != 0) begin
                                inh = 1'b1;
                                tail_cd = tail_cd - 24'd1;
                            end
                            else begin
                                phase = PH_IDLE;
                            end
                            if (rise) begin
                                pend_rej = 1'b1;
                                counts[2]++;
                            end
                        end
                        default: phase = PH_IDLE;
                    endcase
                end
                default: ;
            endcase
            if (emit) counts[1]++;
            if (clr) for (int k = 0; k < 4; k++) counts[k] = '0;
            r.sample = held;
            r.emitted = emit;
            r.inhibit = inh;
            due_results.push_back(r);
        endfunction

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_item(logic [OUT_TDATA_W-1:0] d);
            rej_result_t got;
            rej_result_t want;
            if (due_results.size() == 0) begin
                report("result arrived with no item outstanding");
                return;
            end
            want = due_results.pop_front();
            got = d[147:0];
            compare_field("out_sample", 32'(got.sample), 32'(want.sample));
            compare_field("out_valid", 32'(got.emitted), 32'(want.emitted));
            compare_field("inhibit_active", 32'(got.inhibit), 32'(want.inhibit));
            compare_field("reject_flag", 32'(got.reject), 32'(want.reject));
            compare_field("double_reject_flag", 32'(got.double_reject),
                          32'(want.double_reject));
            compare_field("input_count", got.input_count, want.input_count);
            compare_field("output_count", got.output_count, want.output_count);
            compare_field("reject_count", got.reject_count, want.reject_count);
            compare_field("double_count", got.double_count, want.double_count);
            compare_field("tdata fill", 32'(d[151:148]), 32'd0);
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    pileup_scoreboard sb;

    int   burst_left = 0;
    int   run_left = 0;
    logic level = 1'b0;
    int   rx_left = 0;
    int   rx_style = 0;

    pulse_pileup_rejector_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The output side switches between free running, random, periodic and
    // long stalls, each for a stretch of cycles.
    always @(posedge clk)
    begin
        if (rx_left == 0) begin
            rx_style <= $urandom_range(0, 3);
            rx_left <= $urandom_range(32, 200);
        end
        else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (rx_left % 4) != 0;
            default: m_tready <= (rx_left % 16) == 0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready) sb.check_item(m_tdata);
            if (s_tvalid && s_tready) sb.note_item(s_tdata);
        end
    end

    // The item holds clear_stats, sample_valid and sample from the top bit down.
    task automatic send_item(input logic [17:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_TDATA_W'(d);
        do @(posedge clk); while (!s_tready);
        burst_left--;
    endtask

    // Lets every outstanding result come out with the input held idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] stored;
        case (idx)
            REG_MODE:          stored = {30'd0, value[1:0]};
            REG_INHIBIT_TIME:  stored = {8'd0, value[23:0]};
            REG_DOUBLE_WINDOW: stored = {8'd0, value[23:0]};
            default:           stored = {31'd0, value[0]};
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== stored)
            sb.report($sformatf("register %0d read %h expected %h", idx, prdata, stored));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [1:0] md, input logic [23:0] inh,
                                 input logic [23:0] dw, input logic rt);
        settle();
        write_reg(REG_MODE, {30'd0, md});
        write_reg(REG_INHIBIT_TIME, {8'd0, inh});
        write_reg(REG_DOUBLE_WINDOW, {8'd0, dw});
        write_reg(REG_RETRIGGER, {31'd0, rt});
    endtask

    // Random items: the valid level toggles in runs whose lengths are set
    // against the programmed windows, with single-item glitches mixed in.
    task automatic run_random(input int count, input int max_run);
        logic [15:0] smp;
        logic        clr;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                level = !level;
                run_left = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, max_run);
            end
            run_left--;
            case ($urandom_range(0, 7))
                0:       smp = 16'h0000;
                1:       smp = 16'hFFFF;
                default: smp = 16'($urandom);
            endcase
            clr = ($urandom_range(0, 39) == 0);
            send_item({clr, level, smp});
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [23:0] inh;
        logic [23:0] dw;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Pass-through at reset settings: sample extremes and a clear
        // that lands on an event.
        send_item({1'b0, 1'b0, 16'h0000});
        send_item({1'b0, 1'b1, 16'hFFFF});
        send_item({1'b0, 1'b1, 16'hFFFF});
        send_item({1'b0, 1'b0, 16'h0000});
        send_item({1'b1, 1'b1, 16'h1234});
        send_item({1'b0, 1'b0, 16'hAAAA});
        send_item({1'b0, 1'b1, 16'h5555});
        send_item({1'b0, 1'b0, 16'h0000});

        // Single inhibit: an event, one inside the window, one after it.
        apply_setting(MODE_SINGLE, 24'd3, 24'd2, 1'b0);
        send_item({1'b0, 1'b1, 16'h0101});
        send_item({1'b0, 1'b0, 16'h0202});
        send_item({1'b0, 1'b1, 16'h0303});
        send_item({1'b0, 1'b0, 16'h0404});
        send_item({1'b0, 1'b0, 16'h0505});
        send_item({1'b0, 1'b0, 16'h0606});
        send_item({1'b0, 1'b1, 16'h0707});
        send_item({1'b0, 1'b0, 16'h0808});

        // Double window: a clean pulse, then a double pulse and a retriggered
        // tail.
        apply_setting(MODE_DOUBLE, 24'd2, 24'd2, 1'b1);
        send_item({1'b0, 1'b1, 16'hBEEF});
        for (int k = 0; k < 6; k++) send_item({1'b0, 1'b0, 16'h0000});
        send_item({1'b0, 1'b1, 16'hCAFE});
        send_item({1'b0, 1'b0, 16'h0000});
        send_item({1'b0, 1'b1, 16'hFFFF});
        send_item({1'b0, 1'b0, 16'h0000});
        send_item({1'b0, 1'b1, 16'h0001});
        for (int k = 0; k < 4; k++) send_item({1'b0, 1'b0, 16'h0000});

        // Every mode with and without retrigger, zero windows first.
        for (int p = 0; p < 12; p++) begin
            inh = (p < 3) ? 24'd0 : 24'($urandom_range(0, 12));
            dw = (p < 3) ? 24'd0 : 24'($urandom_range(0, 10));
            apply_setting(2'(p % 3), inh, dw, 1'((p / 3) % 2));
            run_random(110, int'((inh + dw) / 2) + 3);
        end

        // Longest windows last, since they never run out within the run.
        apply_setting(MODE_SINGLE, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        run_random(50, 4);
        apply_setting(MODE_DOUBLE, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        run_random(50, 4);

        settle();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("PASS");
        end
        else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

FILE: files.f
design/pprej_pkg.sv
design/pprej_cfg.sv
design/pprej_core.sv
design/pulse_pileup_rejector_unit.sv
sim/tb_pulse_pileup_rejector_unit.sv
